// ===== hdl/leed_pkg.sv =====
// Shared types and constants for the line editor escape decode block.
`timescale 1ns / 1ps

package leed_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 4;
   localparam int CNT_W  = 6;
   localparam int CSR_IDX_W = 3;

   // Input command codes.
   localparam logic [CMD_W-1:0] CMD_KEY   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKSPACE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UP        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT     = 3'd6;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd27;
   localparam logic [BYTE_W-1:0] RST_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] RST_ENTER     = 8'd13;
   localparam logic [BYTE_W-1:0] RST_UP        = 8'd128;
   localparam logic [BYTE_W-1:0] RST_DOWN      = 8'd129;
   localparam logic [BYTE_W-1:0] RST_LEFT      = 8'd130;
   localparam logic [BYTE_W-1:0] RST_RIGHT     = 8'd131;

   // Characters of the arrow key sequence.
   localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_A        = 8'h41;
   localparam logic [BYTE_W-1:0] CH_B        = 8'h42;
   localparam logic [BYTE_W-1:0] CH_C        = 8'h43;
   localparam logic [BYTE_W-1:0] CH_D        = 8'h44;

   // Escape sequence phase.
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ESC     = 2'd1;
   localparam logic [1:0] PH_BRACKET = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      K_SWALLOWED   = 4'd0,
      K_STORED      = 4'd1,
      K_BACKSPACE   = 4'd2,
      K_ESC_IGNORED = 4'd3,
      K_LINE_CHAR   = 4'd4,
      K_LINE_END    = 4'd5,
      K_POPPED      = 4'd6,
      K_POP_EMPTY   = 4'd7,
      K_CLEARED     = 4'd8
   } kind_type;

   // How the item at the input is handled.
   typedef enum logic [1:0] {
      CLS_NONE   = 2'd0,
      CLS_SINGLE = 2'd1,
      CLS_POP    = 2'd2,
      CLS_ENTER  = 2'd3
   } cls_type;

   typedef struct packed {
      logic req_take;
      logic walk_rd;
      logic load_pop;
      logic load_char;
      logic load_end;
   } ctrl_cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    walk_done;
   } ctrl_status_type;

endpackage

// ===== hdl/leed_ctrl.sv =====
// Controller state machine that sequences items and line walks.
`timescale 1ns / 1ps

module leed_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  leed_pkg::ctrl_status_type ctrl_status,
   output leed_pkg::ctrl_cmd_type    ctrl_cmd
);
   import leed_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_POPRD = 6'b000010,
      S_WNEXT = 6'b000100,
      S_WRD   = 6'b001000,
      S_WSEND = 6'b010000,
      S_SEND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctrl_cmd  = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.req_take = 1'b1;
               case (ctrl_status.cls)
                  CLS_SINGLE: state_in = S_SEND;
                  CLS_POP:    state_in = S_POPRD;
                  CLS_ENTER:  state_in = S_WNEXT;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_POPRD: begin
            ctrl_cmd.load_pop = 1'b1;
            state_in = S_SEND;
         end
         S_WNEXT: begin
            if (ctrl_status.walk_done) begin
               ctrl_cmd.load_end = 1'b1;
               state_in = S_SEND;
            end else begin
               ctrl_cmd.walk_rd = 1'b1;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            ctrl_cmd.load_char = 1'b1;
            state_in = S_WSEND;
         end
         S_WSEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_WNEXT;
            end
         end
         S_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/leed_dpath.sv =====
// Datapath: key decode, line store, count, escape phase and result register.
`timescale 1ns / 1ps

module leed_dpath #(
   parameter int LINE_CAPACITY = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [leed_pkg::CMD_W-1:0]        req_cmd,
   input  logic [leed_pkg::BYTE_W-1:0]       req_key_byte,
   input  logic                              csr_wr_en,
   input  logic [leed_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [leed_pkg::BYTE_W-1:0]       csr_wdata,
   input  leed_pkg::ctrl_cmd_type            ctrl_cmd,
   output leed_pkg::ctrl_status_type         ctrl_status,
   output logic [leed_pkg::KIND_W-1:0]       rsp_kind,
   output logic [leed_pkg::BYTE_W-1:0]       rsp_char_out,
   output logic [leed_pkg::CNT_W-1:0]        rsp_line_length,
   output logic                              rsp_last
);
   import leed_pkg::*;

   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

   logic [BYTE_W-1:0] esc_code_ff, bs_code_ff, enter_code_ff;
   logic [BYTE_W-1:0] up_code_ff, down_code_ff, left_code_ff, right_code_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] line_mem [LINE_CAPACITY];
   logic [BYTE_W-1:0] rd_data_ff;

   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic [CNT_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   // Decode of the item waiting at the input.
   cls_type           cls;
   kind_type          sgl_kind;
   logic [BYTE_W-1:0] sgl_char;
   logic [CNT_W-1:0]  sgl_len;
   logic [CNT_W-1:0]  sgl_count;
   logic [1:0]        sgl_phase;
   logic              sgl_wr;
   logic              store_req;
   logic [BYTE_W-1:0] store_val;
   logic [CNT_W-1:0]  count_m1;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   assign count_m1 = count_ff - 1'b1;

   always_comb begin
      cls       = CLS_NONE;
      sgl_kind  = K_SWALLOWED;
      sgl_char  = '0;
      sgl_len   = count_ff;
      sgl_count = count_ff;
      sgl_phase = phase_ff;
      sgl_wr    = 1'b0;
      store_req = 1'b0;
      store_val = '0;
      case (req_cmd)
         CMD_POP: begin
            if (count_ff != '0) begin
               cls = CLS_POP;
            end else begin
               cls      = CLS_SINGLE;
               sgl_kind = K_POP_EMPTY;
               sgl_len  = '0;
            end
         end
         CMD_CLEAR: begin
            cls       = CLS_SINGLE;
            sgl_kind  = K_CLEARED;
            sgl_len   = '0;
            sgl_count = '0;
         end
         CMD_KEY: begin
            cls = CLS_SINGLE;
            case (phase_ff)
               PH_IDLE: begin
                  if (req_key_byte == esc_code_ff) begin
                     sgl_phase = PH_ESC;
                  end else if (req_key_byte == bs_code_ff) begin
                     sgl_kind = K_BACKSPACE;
                     if (count_ff != '0) begin
                        sgl_count = count_m1;
                        sgl_len   = count_m1;
                     end
                  end else if (req_key_byte == enter_code_ff) begin
                     cls = CLS_ENTER;
                  end else begin
                     store_req = 1'b1;
                     store_val = req_key_byte;
                  end
               end
               PH_ESC: begin
                  if (req_key_byte == CH_LBRACKET) begin
                     sgl_phase = PH_BRACKET;
                  end else begin
                     sgl_phase = PH_IDLE;
                     sgl_kind  = K_ESC_IGNORED;
                  end
               end
               default: begin
                  sgl_phase = PH_IDLE;
                  case (req_key_byte)
                     CH_A: begin
                        store_req = 1'b1;
                        store_val = up_code_ff;
                     end
                     CH_B: begin
                        store_req = 1'b1;
                        store_val = down_code_ff;
                     end
                     CH_C: begin
                        store_req = 1'b1;
                        store_val = left_code_ff;
                     end
                     CH_D: begin
                        store_req = 1'b1;
                        store_val = right_code_ff;
                     end
                     default: sgl_kind = K_ESC_IGNORED;
                  endcase
               end
            endcase
            // A full line drops the character and reports it swallowed.
            if (store_req && (count_ff != CAP)) begin
               sgl_wr    = 1'b1;
               sgl_kind  = K_STORED;
               sgl_char  = store_val;
               sgl_count = count_ff + 1'b1;
               sgl_len   = count_ff + 1'b1;
            end
         end
         default: cls = CLS_NONE;
      endcase
   end

   assign ctrl_status.cls       = cls;
   assign ctrl_status.walk_done = (idx_ff == count_ff);

   assign mem_we  = ctrl_cmd.req_take && (cls == CLS_SINGLE) && sgl_wr;
   assign rd_addr = ctrl_cmd.walk_rd ? idx_ff[ADDR_W-1:0] : count_m1[ADDR_W-1:0];

   always_comb begin
      count_in    = count_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_char_in = rsp_char_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_last_in = rsp_last_ff;
      if (ctrl_cmd.req_take) begin
         case (cls)
            CLS_SINGLE: begin
               count_in    = sgl_count;
               phase_in    = sgl_phase;
               rsp_kind_in = sgl_kind;
               rsp_char_in = sgl_char;
               rsp_len_in  = sgl_len;
               rsp_last_in = 1'b1;
            end
            CLS_POP:   count_in = count_m1;
            CLS_ENTER: idx_in   = '0;
            default:   count_in = count_ff;
         endcase
      end
      if (ctrl_cmd.load_pop) begin
         rsp_kind_in = K_POPPED;
         rsp_char_in = rd_data_ff;
         rsp_len_in  = count_ff;
         rsp_last_in = 1'b1;
      end
      if (ctrl_cmd.load_char) begin
         rsp_kind_in = K_LINE_CHAR;
         rsp_char_in = rd_data_ff;
         rsp_len_in  = count_ff;
         rsp_last_in = 1'b0;
         idx_in      = idx_ff + 1'b1;
      end
      if (ctrl_cmd.load_end) begin
         rsp_kind_in = K_LINE_END;
         rsp_char_in = '0;
         rsp_len_in  = '0;
         rsp_last_in = 1'b1;
         count_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_code_ff   <= RST_ESCAPE;
         bs_code_ff    <= RST_BACKSPACE;
         enter_code_ff <= RST_ENTER;
         up_code_ff    <= RST_UP;
         down_code_ff  <= RST_DOWN;
         left_code_ff  <= RST_LEFT;
         right_code_ff <= RST_RIGHT;
         count_ff      <= '0;
         phase_ff      <= PH_IDLE;
         idx_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ESCAPE:    esc_code_ff   <= csr_wdata;
               CSR_BACKSPACE: bs_code_ff    <= csr_wdata;
               CSR_ENTER:     enter_code_ff <= csr_wdata;
               CSR_UP:        up_code_ff    <= csr_wdata;
               CSR_DOWN:      down_code_ff  <= csr_wdata;
               CSR_LEFT:      left_code_ff  <= csr_wdata;
               CSR_RIGHT:     right_code_ff <= csr_wdata;
               default:       esc_code_ff   <= esc_code_ff;
            endcase
         end
         count_ff <= count_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   // Result register and line store need no reset.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[count_ff[ADDR_W-1:0]] <= sgl_char;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   assign rsp_kind        = rsp_kind_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hdl/line_editor_escape_decode_unit.sv =====
// Top level of the terminal line editor with arrow key escape decoding.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// req       req_valid / req_ready   req_cmd, req_key_byte
// rsp       rsp_valid / rsp_ready   rsp_kind, rsp_char_out, rsp_line_length, rsp_last
// csr       csr_wr_en (no wait)     csr_index, csr_wdata
//
// A key, pop or clear item is decoded and its result registered at the accepting edge, and
// the result is shown the next cycle. A pop on a non-empty line instead first reads the
// registered line store and then loads the read character into the result register.
// Enter walks the line store through its single read port, reading, loading and sending
// each character in turn, followed by the line-end item. Reset is synchronous, clears the
// count and the escape phase and restores the default key codes; the line store holds no
// reset. A stalled result holds the controller in place, and no new item is taken until the
// last result of an item has gone.

module line_editor_escape_decode_unit #(
   parameter int LINE_CAPACITY = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [leed_pkg::CMD_W-1:0]        req_cmd,
   input  logic [leed_pkg::BYTE_W-1:0]       req_key_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [leed_pkg::KIND_W-1:0]       rsp_kind,
   output logic [leed_pkg::BYTE_W-1:0]       rsp_char_out,
   output logic [leed_pkg::CNT_W-1:0]        rsp_line_length,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [leed_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [leed_pkg::BYTE_W-1:0]       csr_wdata
);
   import leed_pkg::*;

   // Commands from the controller and status from the datapath.
   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   // The controller owns the handshakes and the order of the line walk.
   leed_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctrl_status (ctrl_status),
      .ctrl_cmd    (ctrl_cmd)
   );

   // The datapath classifies the waiting item, holds the line and builds each result.
   leed_dpath #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_key_byte    (req_key_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .ctrl_cmd        (ctrl_cmd),
      .ctrl_status     (ctrl_status),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

endmodule
